// ----- src/tij_pkg.sv -----
// Shared types and widths for the tetrahedron inverse Jacobian unit.
// No dependencies.
package tij_pkg;

  localparam int unsigned W = 32;             // coordinate and result word
  localparam int unsigned DEF_FRAC_BITS = 16;
  localparam int unsigned EW = W + 1;         // edge difference
  localparam int unsigned PW = 2 * EW;        // 2x2 product
  localparam int unsigned CW = PW + 1;        // cofactor
  localparam int unsigned LB = W + 2;         // low split of a cofactor
  localparam int unsigned HB = CW - LB;       // high split of a cofactor
  localparam int unsigned DW = EW + CW + 2;   // determinant
  localparam int unsigned QB = W + 2;         // quotient bits of 2N/D
  localparam int unsigned NL = 9;             // matrix entries
  localparam int unsigned LATENCY = QB + 9;

  typedef struct packed {
    logic signed [W-1:0] x_v0;
    logic signed [W-1:0] x_v1;
    logic signed [W-1:0] x_v2;
    logic signed [W-1:0] x_v3;
    logic signed [W-1:0] y_v0;
    logic signed [W-1:0] y_v1;
    logic signed [W-1:0] y_v2;
    logic signed [W-1:0] y_v3;
    logic signed [W-1:0] z_v0;
    logic signed [W-1:0] z_v1;
    logic signed [W-1:0] z_v2;
    logic signed [W-1:0] z_v3;
  } tij_in_t;

  typedef struct packed {
    logic signed [W-1:0] inv_00;
    logic signed [W-1:0] inv_01;
    logic signed [W-1:0] inv_02;
    logic signed [W-1:0] inv_10;
    logic signed [W-1:0] inv_11;
    logic signed [W-1:0] inv_12;
    logic signed [W-1:0] inv_20;
    logic signed [W-1:0] inv_21;
    logic signed [W-1:0] inv_22;
    logic                singular;
  } tij_out_t;

endpackage

// ----- src/tij_jac_cof.sv -----
// Edge vectors, 2x2 products and cofactors: three register stages.
// Depends on tij_pkg.
module tij_jac_cof import tij_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tij_in_t              in_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] cof_o [3][3],
  output logic signed [EW-1:0] row0_o [3]
);

  logic [2:0] v_q;
  logic signed [W-1:0]  vtx [3][4];
  logic signed [EW-1:0] m_d [3][3], m_q [3][3];
  logic signed [PW-1:0] pa_d [3][3], pa_q [3][3], pb_d [3][3], pb_q [3][3];
  logic signed [EW-1:0] r0_q [3], r0b_q [3];
  logic signed [CW-1:0] cof_d [3][3], cof_q [3][3];

  assign vtx[0] = '{in_i.x_v0, in_i.x_v1, in_i.x_v2, in_i.x_v3};
  assign vtx[1] = '{in_i.y_v0, in_i.y_v1, in_i.y_v2, in_i.y_v3};
  assign vtx[2] = '{in_i.z_v0, in_i.z_v1, in_i.z_v2, in_i.z_v3};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_d[r][c] = EW'(vtx[r][c+1]) - EW'(vtx[r][0]);
      end
    end
  end

  // cofactor(r,c) = m[r1][c1]*m[r2][c2] - m[r1][c2]*m[r2][c1], indices mod 3
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pa_d[r][c] = m_q[(r+1)%3][(c+1)%3] * m_q[(r+2)%3][(c+2)%3];
        pb_d[r][c] = m_q[(r+1)%3][(c+2)%3] * m_q[(r+2)%3][(c+1)%3];
        cof_d[r][c] = CW'(pa_q[r][c]) - CW'(pb_q[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    cof_q <= cof_d;
    r0_q  <= m_q[0];
    r0b_q <= r0_q;
  end

  assign valid_o = v_q[2];
  assign cof_o   = cof_q;
  assign row0_o  = r0b_q;

endmodule

// ----- src/tij_det.sv -----
// Determinant by split partial products, then magnitudes and signs: four stages.
// Depends on tij_pkg.
module tij_det import tij_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] cof_i [3][3],
  input  logic signed [EW-1:0] row0_i [3],
  output logic                 valid_o,
  output logic                 sing_o,
  output logic [DW-1:0]        den_o,
  output logic [CW-1:0]        mag_o [NL],
  output logic                 neg_o [NL]
);

  localparam int unsigned HPW = EW + HB;
  localparam int unsigned LPW = EW + LB + 1;
  localparam int unsigned SHW = HPW + 2;
  localparam int unsigned SLW = LPW + 2;

  logic [3:0] v_q;
  logic signed [HPW-1:0] ph_d [3], ph_q [3];
  logic signed [LPW-1:0] pl_d [3], pl_q [3];
  logic signed [SHW-1:0] sh_d, sh_q;
  logic signed [SLW-1:0] sl_d, sl_q;
  logic signed [DW-1:0]  det_d, det_q;
  logic signed [CW-1:0]  c4_q [3][3], c5_q [3][3], c6_q [3][3];
  logic [DW-1:0]         den_d, den_q;
  logic                  sing_d, sing_q;
  logic [CW-1:0]         mag_d [NL], mag_q [NL];
  logic                  neg_d [NL], neg_q [NL];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ph_d[k] = row0_i[k] * $signed(cof_i[0][k][CW-1:LB]);
      pl_d[k] = row0_i[k] * $signed({1'b0, cof_i[0][k][LB-1:0]});
    end
    sh_d  = SHW'(ph_q[0]) + SHW'(ph_q[1]) + SHW'(ph_q[2]);
    sl_d  = SLW'(pl_q[0]) + SLW'(pl_q[1]) + SLW'(pl_q[2]);
    det_d = (DW'(sh_q) <<< LB) + DW'(sl_q);
  end

  // inverse entry (r,c) takes cofactor (c,r)
  always_comb begin
    sing_d = (det_q == '0);
    den_d  = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    for (int l = 0; l < NL; l++) begin
      mag_d[l] = c6_q[l%3][l/3][CW-1] ? CW'(-c6_q[l%3][l/3]) : CW'(c6_q[l%3][l/3]);
      neg_d[l] = c6_q[l%3][l/3][CW-1] ^ det_q[DW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q   <= ph_d;
    pl_q   <= pl_d;
    c4_q   <= cof_i;
    sh_q   <= sh_d;
    sl_q   <= sl_d;
    c5_q   <= c4_q;
    det_q  <= det_d;
    c6_q   <= c5_q;
    den_q  <= den_d;
    sing_q <= sing_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
  end

  assign valid_o = v_q[3];
  assign sing_o  = sing_q;
  assign den_o   = den_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

// ----- src/tij_div_pipe.sv -----
// Nine-lane pipelined restoring divider, one quotient bit per stage,
// with rounding, saturation and singular masking. Depends on tij_pkg.
module tij_div_pipe import tij_pkg::*; #(
  parameter int unsigned FracBits = DEF_FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic          sing_i,
  input  logic [DW-1:0] den_i,
  input  logic [CW-1:0] mag_i [NL],
  input  logic          neg_i [NL],
  output logic          valid_o,
  output tij_out_t      res_o
);

  localparam int unsigned SB = 2 * FracBits + 1;  // 2N = |cof| << SB
  localparam int unsigned XW = CW + SB;
  localparam int unsigned HW = XW - QB;
  localparam logic [QB-1:0] HalfRange = QB'(2 ** (W - 1));
  localparam logic [QB-1:0] MaxPos    = QB'(2 ** (W - 1) - 1);

  logic [QB+1:0]  v_q;
  logic           s_q   [QB+1];
  logic [DW-1:0]  d_q   [QB+1];
  logic [DW-1:0]  rem_q [QB+1][NL];
  logic [QB-1:0]  low_q [QB+1][NL];
  logic [QB-1:0]  quo_q [QB+1][NL];
  logic           ng_q  [QB+1][NL];
  logic           ov_q  [QB+1][NL];

  logic [XW-1:0]  x0 [NL];
  logic [DW-1:0]  h0 [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      x0[l] = {mag_i[l], SB'(0)};
      h0[l] = {(DW-HW)'(0), x0[l][XW-1:QB]};
    end
  end

  always_ff @(posedge clk_i) begin
    s_q[0] <= sing_i;
    d_q[0] <= den_i;
    for (int l = 0; l < NL; l++) begin
      rem_q[0][l] <= h0[l];
      low_q[0][l] <= x0[l][QB-1:0];
      quo_q[0][l] <= '0;
      ng_q[0][l]  <= neg_i[l];
      ov_q[0][l]  <= (h0[l] >= den_i);  // quotient at least 2^QB
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [DW:0] t  [NL];
    logic        ge [NL];

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        t[l]  = {rem_q[s-1][l], low_q[s-1][l][QB-1]};
        ge[l] = (t[l] >= {1'b0, d_q[s-1]});
      end
    end

    always_ff @(posedge clk_i) begin
      s_q[s] <= s_q[s-1];
      d_q[s] <= d_q[s-1];
      for (int l = 0; l < NL; l++) begin
        rem_q[s][l] <= ge[l] ? DW'(t[l] - {1'b0, d_q[s-1]}) : DW'(t[l]);
        low_q[s][l] <= {low_q[s-1][l][QB-2:0], 1'b0};
        quo_q[s][l] <= {quo_q[s-1][l][QB-2:0], ge[l]};
        ng_q[s][l]  <= ng_q[s-1][l];
        ov_q[s][l]  <= ov_q[s-1][l];
      end
    end
  end

  // floor(2N/D) + 1, halved, rounds half away from zero
  logic [QB:0]    inc [NL];
  logic [QB-1:0]  qr  [NL];
  logic [W-1:0]   ent [NL];
  tij_out_t       res_d, res_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      inc[l] = {1'b0, quo_q[QB][l]} + (QB+1)'(1);
      qr[l]  = inc[l][QB:1];
      if (s_q[QB]) begin
        ent[l] = '0;
      end else if (ng_q[QB][l] && (qr[l] != '0)) begin
        if (ov_q[QB][l] || (qr[l] > HalfRange)) begin
          ent[l] = {1'b1, (W-1)'(0)};
        end else begin
          ent[l] = W'(-qr[l]);
        end
      end else if (ov_q[QB][l] || (qr[l] > MaxPos)) begin
        ent[l] = {1'b0, {(W-1){1'b1}}};
      end else begin
        ent[l] = qr[l][W-1:0];
      end
    end
    res_d.inv_00   = ent[0];
    res_d.inv_01   = ent[1];
    res_d.inv_02   = ent[2];
    res_d.inv_10   = ent[3];
    res_d.inv_11   = ent[4];
    res_d.inv_12   = ent[5];
    res_d.inv_20   = ent[6];
    res_d.inv_21   = ent[7];
    res_d.inv_22   = ent[8];
    res_d.singular = s_q[QB];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[QB:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = v_q[QB+1];
  assign res_o   = res_q;

endmodule

// ----- src/tet_inverse_jacobian_unit.sv -----
// Tetrahedron inverse Jacobian, top level.
// Depends on tij_pkg, tij_jac_cof, tij_det, tij_div_pipe.
//
// Usage:
//   Command channel: drive the four vertex coordinates on in_i and raise
//   start_i; the item is taken at any edge with start_i high and busy_o
//   low. busy_o is always low: the pipeline takes one item every cycle.
//   Result channel: valid_o strobes for one cycle with res_o holding the
//   nine Q16.16 inverse entries and the singular flag. Results leave in
//   the order items entered.
//   Stages: 3 for edges and cofactors, 4 for the determinant and signs,
//   W + 4 for the divider (one quotient bit per stage, plus entry and
//   round/saturate registers). Throughput: one item per cycle, set by
//   the fully pipelined bit-per-stage divider.
//   Reset (rst_ni low, asynchronous) clears all valid bits; items in
//   flight are dropped. The receiver cannot stall, so nothing is held.
//   Singular matrices return all-zero entries with singular set.
module tet_inverse_jacobian_unit import tij_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  tij_in_t  in_i,
  output logic     valid_o,
  output tij_out_t res_o
);

  logic                 acc;
  logic                 jc_valid;
  logic signed [CW-1:0] jc_cof [3][3];
  logic signed [EW-1:0] jc_row0 [3];
  logic                 dt_valid;
  logic                 dt_sing;
  logic [DW-1:0]        dt_den;
  logic [CW-1:0]        dt_mag [NL];
  logic                 dt_neg [NL];

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  // edges from vertex 0 and the nine cofactors
  tij_jac_cof u_jac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .in_i    (in_i),
    .valid_o (jc_valid),
    .cof_o   (jc_cof),
    .row0_o  (jc_row0)
  );

  // exact determinant along row 0, then |det| and per-entry signs
  tij_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (jc_valid),
    .cof_i   (jc_cof),
    .row0_i  (jc_row0),
    .valid_o (dt_valid),
    .sing_o  (dt_sing),
    .den_o   (dt_den),
    .mag_o   (dt_mag),
    .neg_o   (dt_neg)
  );

  // cofactor * 2^(2F) / det, rounded and saturated, all nine lanes
  tij_div_pipe #(
    .FracBits (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dt_valid),
    .sing_i  (dt_sing),
    .den_i   (dt_den),
    .mag_i   (dt_mag),
    .neg_i   (dt_neg),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule

// ----- src/tij_checker.sv -----
// Port-level checks for the inverse Jacobian unit, bound to the top level.
// Depends on tij_pkg and tet_inverse_jacobian_unit.
module tij_checker import tij_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     valid_o,
  input tij_out_t res_o
);

  // each taken item comes out after the fixed latency
  a_fwd_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY valid_o)
    else $error("item taken without result at fixed latency");

  // no result without an item taken the fixed latency earlier
  a_bwd_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result with no matching item");

  // singular results carry all-zero entries
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.singular) |->
      (res_o.inv_00 == '0) && (res_o.inv_01 == '0) && (res_o.inv_02 == '0) &&
      (res_o.inv_10 == '0) && (res_o.inv_11 == '0) && (res_o.inv_12 == '0) &&
      (res_o.inv_20 == '0) && (res_o.inv_21 == '0) && (res_o.inv_22 == '0))
    else $error("singular result with nonzero entry");

endmodule

bind tet_inverse_jacobian_unit tij_checker u_tij_checker (.*);
